>>> rtl/urb_pkg.sv
package urb_pkg;

  // fixed payload widths
  localparam int DATA_W    = 8;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 4;
  localparam int TX_FILL_W = 7;
  localparam int RX_FILL_W = 8;

  // default ring depths
  localparam int TX_DEPTH_DEF = 64;
  localparam int RX_DEPTH_DEF = 128;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_QUEUE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TXRDY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RECV  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd4;

  // break indication within line status
  localparam int BREAK_BIT = 0;

  // ring control and status
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } ring_stat_t;

endpackage

>>> rtl/urb_in_if.sv
interface urb_in_if;
  logic                          valid;
  logic                          ready;
  logic [urb_pkg::KIND_W-1:0]    kind;
  logic [urb_pkg::DATA_W-1:0]    data;
  logic                          line_error;
  logic [urb_pkg::STATUS_W-1:0]  line_status;

  modport source (output valid, kind, data, line_error, line_status, input ready);
  modport sink   (input valid, kind, data, line_error, line_status, output ready);
endinterface

>>> rtl/urb_out_if.sv
interface urb_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic                           tx_valid;
  logic [urb_pkg::DATA_W-1:0]     tx_byte;
  logic                           rx_valid;
  logic [urb_pkg::DATA_W-1:0]     rx_byte;
  logic [urb_pkg::TX_FILL_W-1:0]  tx_fill;
  logic [urb_pkg::RX_FILL_W-1:0]  rx_fill;
  logic                           tx_irq_on;
  logic                           break_seen;
  logic [urb_pkg::STATUS_W-1:0]   error_bits;

  modport source (output valid, accepted, tx_valid, tx_byte, rx_valid, rx_byte, tx_fill,
                  rx_fill, tx_irq_on, break_seen, error_bits, input ready);
  modport sink   (input valid, accepted, tx_valid, tx_byte, rx_valid, rx_byte, tx_fill,
                  rx_fill, tx_irq_on, break_seen, error_bits, output ready);
endinterface

>>> rtl/uart_tx_rx_ring_buffers.sv
// serial port buffering: a transmit ring and a receive ring, each held in a
// single-port-write / registered-read memory. one request is taken per cycle
// while the output channel is not stalled; its result waits in stage 1 for
// the memory read of the ring being popped, then passes to the output register.
// request kinds: queue a transmit byte, transmitter ready (pop oldest
// transmit byte), line byte received, read a received byte, flush both
// rings. cfg_wr_data written with cfg_wr_en sets line status checking (reset
// on): a received byte with line_error set is then dropped and its status
// bits latched into error_bits. every result carries fill levels, transmit
// interrupt enable, break flag and latched error bits after the request.
// ring contents are not cleared at reset; only the pointers and counts are.
module uart_tx_rx_ring_buffers #(
  parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  urb_in_if.sink    in_if,
  urb_out_if.source out_if,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  // configuration
  logic check_r;

  // block-level flags
  logic                           irq_r, irq_nxt;
  logic                           brk_r, brk_nxt;
  logic [urb_pkg::STATUS_W-1:0]   err_r, err_nxt;

  // ring interfaces
  urb_pkg::ring_ctrl_t        tx_ctrl, rx_ctrl;
  urb_pkg::ring_stat_t        tx_stat, rx_stat;
  logic [urb_pkg::DATA_W-1:0] tx_rdata, rx_rdata;
  logic [TX_CNT_W-1:0]        tx_count;
  logic [RX_CNT_W-1:0]        rx_count;

  // stage 1: request done, waiting for memory read data
  logic s1_valid_r;
  logic s1_acc_r, s1_acc_nxt;
  logic s1_txv_r, s1_rxv_r;
  logic s1_move;

  // output register
  logic                           out_valid_r;
  logic                           out_acc_r;
  logic                           out_txv_r;
  logic [urb_pkg::DATA_W-1:0]     out_txb_r;
  logic                           out_rxv_r;
  logic [urb_pkg::DATA_W-1:0]     out_rxb_r;
  logic [urb_pkg::TX_FILL_W-1:0]  out_txf_r;
  logic [urb_pkg::RX_FILL_W-1:0]  out_rxf_r;
  logic                           out_irq_r;
  logic                           out_brk_r;
  logic [urb_pkg::STATUS_W-1:0]   out_err_r;

  logic acc;
  logic drop_bad;

  // stage 1 may move on when the output register is free or being taken
  assign s1_move     = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || s1_move;
  assign acc         = in_if.valid && in_if.ready;
  assign drop_bad    = check_r && in_if.line_error;

  // request decode: ring operations and flag updates
  always_comb begin
    tx_ctrl    = '0;
    rx_ctrl    = '0;
    irq_nxt    = irq_r;
    brk_nxt    = brk_r;
    err_nxt    = err_r;
    s1_acc_nxt = 1'b0;
    if (acc) begin
      case (in_if.kind)
        urb_pkg::KIND_QUEUE: begin
          if (!tx_stat.full) begin
            tx_ctrl.push = 1'b1;
            irq_nxt      = 1'b1;
            s1_acc_nxt   = 1'b1;
          end
        end
        urb_pkg::KIND_TXRDY: begin
          tx_ctrl.pop = !tx_stat.empty;
          // interrupt drops once nothing is left after this pop
          if (tx_stat.empty || tx_stat.last) begin
            irq_nxt = 1'b0;
          end
        end
        urb_pkg::KIND_RECV: begin
          brk_nxt = in_if.line_status[urb_pkg::BREAK_BIT];
          if (drop_bad) begin
            err_nxt = in_if.line_status;
          end else if (!rx_stat.full) begin
            rx_ctrl.push = 1'b1;
            s1_acc_nxt   = 1'b1;
          end
        end
        urb_pkg::KIND_READ: begin
          rx_ctrl.pop = !rx_stat.empty;
        end
        urb_pkg::KIND_FLUSH: begin
          tx_ctrl.flush = 1'b1;
          rx_ctrl.flush = 1'b1;
          brk_nxt       = 1'b0;
          irq_nxt       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  urb_ring #(
    .DEPTH (TX_DEPTH),
    .CNT_W (TX_CNT_W)
  ) u_tx_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (tx_ctrl),
    .wdata (in_if.data),
    .rdata (tx_rdata),
    .count (tx_count),
    .stat  (tx_stat)
  );

  urb_ring #(
    .DEPTH (RX_DEPTH),
    .CNT_W (RX_CNT_W)
  ) u_rx_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (rx_ctrl),
    .wdata (in_if.data),
    .rdata (rx_rdata),
    .count (rx_count),
    .stat  (rx_stat)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r     <= 1'b1;
      irq_r       <= 1'b0;
      brk_r       <= 1'b0;
      err_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        check_r <= cfg_wr_data;
      end
      irq_r      <= irq_nxt;
      brk_r      <= brk_nxt;
      err_r      <= err_nxt;
      s1_valid_r <= acc || (s1_valid_r && !s1_move);
      if (s1_valid_r && s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage 1 payload: only taken with a new request
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_acc_r <= s1_acc_nxt;
      s1_txv_r <= tx_ctrl.pop;
      s1_rxv_r <= rx_ctrl.pop;
    end
  end

  // output payload; counts and flags are stable while stage 1 is occupied
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_move) begin
      out_acc_r <= s1_acc_r;
      out_txv_r <= s1_txv_r;
      out_txb_r <= s1_txv_r ? tx_rdata : '0;
      out_rxv_r <= s1_rxv_r;
      out_rxb_r <= s1_rxv_r ? rx_rdata : '0;
      out_txf_r <= urb_pkg::TX_FILL_W'(tx_count);
      out_rxf_r <= urb_pkg::RX_FILL_W'(rx_count);
      out_irq_r <= irq_r;
      out_brk_r <= brk_r;
      out_err_r <= err_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.accepted   = out_acc_r;
  assign out_if.tx_valid   = out_txv_r;
  assign out_if.tx_byte    = out_txb_r;
  assign out_if.rx_valid   = out_rxv_r;
  assign out_if.rx_byte    = out_rxb_r;
  assign out_if.tx_fill    = out_txf_r;
  assign out_if.rx_fill    = out_rxf_r;
  assign out_if.tx_irq_on  = out_irq_r;
  assign out_if.break_seen = out_brk_r;
  assign out_if.error_bits = out_err_r;

endmodule

>>> rtl/urb_ring.sv
module urb_ring #(
  parameter int DEPTH = urb_pkg::TX_DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  urb_pkg::ring_ctrl_t        ctrl,
  input  logic [urb_pkg::DATA_W-1:0] wdata,
  output logic [urb_pkg::DATA_W-1:0] rdata,
  output logic [CNT_W-1:0]           count,
  output urb_pkg::ring_stat_t        stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [urb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [urb_pkg::DATA_W-1:0] rdata_r;
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [PTR_W-1:0]           tail_r, tail_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;

  // memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[head_r] <= wdata;
    end
    if (ctrl.pop) begin
      rdata_r <= mem[tail_r];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.flush) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (ctrl.push) begin
        head_nxt  = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        count_nxt = count_r + CNT_W'(1);
      end
      if (ctrl.pop) begin
        tail_nxt  = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign rdata      = rdata_r;
  assign count      = count_r;
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.last  = (count_r == CNT_W'(1));

endmodule
